@@ rtl/ftrc_pkg.sv @@
`default_nettype none

package ftrc_pkg;

   localparam int MAX_POSITIONS_DEF = 32768;
   localparam int COUNT_W           = 32;
   localparam int POS_W             = 16;
   localparam int SIZE_W            = 16;

   localparam logic [SIZE_W-1:0] TREE_SIZE_RESET = 16'd32768;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_QUERY  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_READ,
      ST_INS_WRITE,
      ST_Q_READ,
      ST_Q_ACC,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

@@ rtl/ftrc_count_ram.sv @@
`default_nettype none

module ftrc_count_ram
   import ftrc_pkg::*;
#(
   parameter int DEPTH  = MAX_POSITIONS_DEF + 1,
   parameter int ADDR_W = $clog2(MAX_POSITIONS_DEF + 1)
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire logic [COUNT_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output logic      [COUNT_W-1:0] rd_data
);

   logic [COUNT_W-1:0] mem [DEPTH];
   logic [COUNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/fenwick_tree_range_count.sv @@
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_operation, req_position, req_left_position
// rsp       out        rsp_valid/rsp_ready    rsp_range_count
// csr       in         csr_valid/csr_ready    csr_tree_size
//
// One counter memory port pair sets the pace: each tree node is read, then written or accumulated.
// Insert: a read state and a write state per node on the upward walk.
// Query: a read state and an accumulate state per node over both prefix walks, then a finish state.
// After reset a clearing pass over all MAX_POSITIONS+1 counters holds off requests; csr is taken.
// A finished count waits in the output register; a later query stalls only at its end.

`default_nettype none

module fenwick_tree_range_count
   import ftrc_pkg::*;
#(
   parameter int MAX_POSITIONS = MAX_POSITIONS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_operation,
   input  wire logic [POS_W-1:0]   req_position,
   input  wire logic [POS_W-1:0]   req_left_position,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [COUNT_W-1:0] rsp_range_count,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [SIZE_W-1:0]  csr_tree_size
);

   localparam int W    = $clog2(MAX_POSITIONS + 1);
   localparam int SZ_W = (W > POS_W) ? W : POS_W;
   localparam int IW   = W + 1;

   localparam logic [SZ_W-1:0] MAX_EXT  = SZ_W'(MAX_POSITIONS);
   localparam logic [W-1:0]    MAX_ADDR = W'(MAX_POSITIONS);

   state_type          state_ff, state_in;
   logic [SIZE_W-1:0]  tree_size_ff;
   logic [W-1:0]       clr_ff, clr_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [W-1:0]       low_ff, low_in;
   logic [W-1:0]       lim_ff, lim_in;
   logic               phase_ff, phase_in;
   logic [COUNT_W-1:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic               wr_en;
   logic [W-1:0]       wr_addr;
   logic [COUNT_W-1:0] wr_data;
   logic [COUNT_W-1:0] rd_data;

   logic [SZ_W-1:0]    size_ext, act_ext, pos_ext, left_ext, right_cl, left1_ext, left1_cl;
   logic [W-1:0]       act_size;
   logic [IW-1:0]      low_bit, idx_step, lim_ext;
   logic [COUNT_W-1:0] add_a, add_b, add_sum;
   logic               add_cin;
   logic               req_fire;

   ftrc_count_ram #(
      .DEPTH  (MAX_POSITIONS + 1),
      .ADDR_W (W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff[W-1:0]),
      .rd_data (rd_data)
   );

   // active size and clamped walk starts
   always_comb begin
      size_ext  = SZ_W'(tree_size_ff);
      act_ext   = (size_ext > MAX_EXT) ? MAX_EXT : size_ext;
      act_size  = act_ext[W-1:0];
      pos_ext   = SZ_W'(req_position);
      left_ext  = SZ_W'(req_left_position);
      right_cl  = (pos_ext > act_ext) ? act_ext : pos_ext;
      left1_ext = left_ext - SZ_W'(1);
      left1_cl  = (left1_ext > act_ext) ? act_ext : left1_ext;
   end

   // shared index step and counter adder
   always_comb begin
      low_bit  = idx_ff & (~idx_ff + IW'(1));
      idx_step = (state_ff == ST_INS_WRITE) ? (idx_ff + low_bit) : (idx_ff - low_bit);
      lim_ext  = {1'b0, lim_ff};
      if (state_ff == ST_INS_WRITE) begin
         add_a   = rd_data;
         add_b   = '0;
         add_cin = 1'b1;
      end else begin
         add_a   = acc_ff;
         add_b   = phase_ff ? ~rd_data : rd_data;
         add_cin = phase_ff;
      end
      add_sum = add_a + add_b + COUNT_W'(add_cin);
   end

   assign req_fire = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      low_in       = low_ff;
      lim_in       = lim_ff;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[W-1:0];
      wr_data      = add_sum;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + W'(1);
            if (clr_ff == MAX_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               lim_in = act_size;
               if (req_operation == OP_INSERT) begin
                  if (pos_ext != '0 && pos_ext <= act_ext) begin
                     idx_in   = {1'b0, pos_ext[W-1:0]};
                     state_in = ST_INS_READ;
                  end
               end else begin
                  acc_in   = '0;
                  phase_in = 1'b0;
                  state_in = ST_Q_READ;
                  if (left_ext > pos_ext) begin
                     idx_in = '0;
                     low_in = '0;
                  end else begin
                     idx_in = {1'b0, right_cl[W-1:0]};
                     low_in = (left_ext == '0) ? '0 : left1_cl[W-1:0];
                  end
               end
            end
         end
         ST_INS_READ: begin
            state_in = ST_INS_WRITE;
         end
         ST_INS_WRITE: begin
            wr_en  = 1'b1;
            idx_in = idx_step;
            if (idx_step > lim_ext) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_INS_READ;
            end
         end
         ST_Q_READ: begin
            if (idx_ff == '0) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  idx_in   = {1'b0, low_ff};
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               state_in = ST_Q_ACC;
            end
         end
         ST_Q_ACC: begin
            acc_in   = add_sum;
            idx_in   = idx_step;
            state_in = ST_Q_READ;
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         tree_size_ff <= TREE_SIZE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            tree_size_ff <= csr_tree_size;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      low_ff       <= low_in;
      lim_ff       <= lim_in;
      phase_ff     <= phase_in;
      acc_ff       <= acc_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");

   a_clear_writes_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (wr_en && wr_data == '0))
      else $error("clearing pass writes non-zero data");

   a_query_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Q_READ) |-> (idx_ff <= lim_ext && low_ff <= lim_ff))
      else $error("query walk beyond active size");

   a_insert_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_READ) |-> (idx_ff != '0 && idx_ff <= lim_ext))
      else $error("insert walk at invalid node");

   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_operation == OP_QUERY) |=> (state_ff == ST_Q_READ && !phase_ff))
      else $error("query did not start its walk");
`endif

endmodule

`default_nettype wire
